[rtl/hermite_resampling_sample_player_top_defines.svh]
// Assertion macros for the Hermite resampling sample player.
// Included by the modules that carry concurrent checks; needs clk and rst_n in scope.
`ifndef HERMITE_RESAMPLING_SAMPLE_PLAYER_TOP_DEFINES_SVH
`define HERMITE_RESAMPLING_SAMPLE_PLAYER_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define HRSP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define HRSP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/hrsp_pkg.sv]
// Shared types, codes and constants of the Hermite resampling sample player.
// No dependencies; imported by every module of the block.
package hrsp_pkg;

  // Store geometry and number formats
  localparam int MAX_FRAMES  = 4096;
  localparam int FRAME_AW    = $clog2(MAX_FRAMES);
  localparam int LEN_W       = FRAME_AW + 1;
  localparam int SAMPLE_W    = 16;
  localparam int FRAC_W      = 16;
  localparam int PHASE_W     = FRAME_AW + FRAC_W;
  localparam int RATE_W      = 18;
  localparam int GAIN_W      = 16;

  // Shared multiply-accumulate unit widths
  localparam int ACC_W       = 22;
  localparam int MUL_B_W     = 17;
  localparam int PROD_W      = ACC_W + MUL_B_W;

  // Request codes
  localparam logic [1:0] REQ_WRITE   = 2'd0;
  localparam logic [1:0] REQ_PLAY    = 2'd1;
  localparam logic [1:0] REQ_RESTART = 2'd2;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 18;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOP   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAMES = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STEREO = 3'd4;

  // Configuration reset values
  localparam logic [GAIN_W-1:0] GAIN_RST   = 16'd32768;
  localparam logic [RATE_W-1:0] RATE_RST   = 18'd65536;
  localparam logic [LEN_W-1:0]  FRAMES_RST = 13'd4096;
  localparam logic [LEN_W-1:0]  LEN_MIN    = 13'd4;
  localparam logic [LEN_W-1:0]  LEN_MAX    = 13'd4096;

  // Rounding constant for the gain step (one half in Q.16)
  localparam logic [FRAC_W-1:0] ROUND_HALF = 16'h8000;

  typedef struct packed {
    logic        [1:0]          req_type;
    logic        [FRAME_AW-1:0] frame_index;
    logic signed [SAMPLE_W-1:0] sample_left;
    logic signed [SAMPLE_W-1:0] sample_right;
  } hrsp_in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] out_left;
    logic signed [SAMPLE_W-1:0] out_right;
    logic                       past_end;
  } hrsp_out_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left;
    logic signed [SAMPLE_W-1:0] right;
  } hrsp_frame_t;

  // Store write port
  typedef struct packed {
    logic                en;
    logic [FRAME_AW-1:0] addr;
    hrsp_frame_t         data;
  } hrsp_mem_wr_t;

  // One operation of the shared MAC: res = ((res * mul_b + rnd * 2^15) >>> 16) + addend
  typedef struct packed {
    logic                    en;
    logic                    rnd;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [ACC_W-1:0]   addend;
  } hrsp_mac_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_READ,
    ST_COEF,
    ST_MAC,
    ST_SAT
  } hrsp_state_t;

endpackage

[rtl/hermite_resampling_sample_player_top.sv]
// Top level of the Hermite resampling sample player: sequencer, registers, phase.
// Depends on hrsp_pkg, hrsp_store, hrsp_mac and the assertion macro header.
//
// Write and restart words are taken one per cycle, back to back. A play word
// keeps busy high until done, and its result strobes on out_valid in the cycle
// busy falls; no new word is taken while one runs. The play rate is set by the
// single store read port (four neighbour frames, one per cycle) and the single
// shared multiplier (four multiply steps per channel, two channels). A play word
// that finds stopped playback returns its silent result from ST_SETUP. Results
// cannot be held off: out_valid is high for exactly one cycle per play word.
// The sample store is not cleared at reset; play only over written frames.
module hermite_resampling_sample_player_top import hrsp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  hrsp_in_t              in_word,
  output logic                  out_valid,
  output hrsp_out_t             out_word,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

`include "hermite_resampling_sample_player_top_defines.svh"

  localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(32767);
  localparam logic signed [ACC_W-1:0] SAT_MIN = -ACC_W'(32768);

  // configuration registers
  logic [GAIN_W-1:0] gain_r;
  logic [RATE_W-1:0] rate_r;
  logic              loop_r;
  logic [LEN_W-1:0]  frames_r;
  logic              stereo_r;

  // control and playback state
  hrsp_state_t          state_r, state_nxt;
  logic [PHASE_W-1:0]   phase_r, phase_nxt;
  logic                 fin_r, fin_nxt;
  logic [2:0]           cnt_r, cnt_nxt;
  logic                 ch_r, ch_nxt;
  logic                 out_valid_r, out_valid_nxt;

  // payload registers
  logic [FRAME_AW-1:0]     idx_r, idx_nxt;
  logic [FRAME_AW-1:0]     im_r, im_nxt;
  logic [FRAME_AW-1:0]     i1_r, i1_nxt;
  logic [FRAME_AW-1:0]     i2_r, i2_nxt;
  hrsp_frame_t             y_r [4];
  logic signed [ACC_W-1:0] coef_b_r, coef_c_r, coef_d_r;
  logic signed [SAMPLE_W-1:0] sat_left_r;
  hrsp_out_t               out_word_r, out_word_nxt;

  // datapath wires
  logic                 accept;
  logic [LEN_W-1:0]     len;
  logic [FRAME_AW-1:0]  idx_raw;
  logic                 over;
  logic                 stopped;
  logic [LEN_W-1:0]     idx_ext;
  logic [FRAME_AW-1:0]  rd_addr;
  hrsp_frame_t          rd_data;
  hrsp_mem_wr_t         mem_wr;
  hrsp_mac_op_t         mac_op;
  logic signed [ACC_W-1:0] mac_res;
  logic signed [ACC_W-1:0] ym, y0, y1, y2;
  logic signed [ACC_W-1:0] coef_a, coef_b, coef_c, coef_d;
  logic signed [SAMPLE_W-1:0] sat_val;
  logic [PHASE_W:0]     next_phase;
  logic [PHASE_W:0]     end_phase;

  assign accept = start && (state_r == ST_IDLE);

  // used length clamped to the legal range
  always_comb begin
    if (frames_r < LEN_MIN) begin
      len = LEN_MIN;
    end else if (frames_r > LEN_MAX) begin
      len = LEN_MAX;
    end else begin
      len = frames_r;
    end
  end

  assign idx_raw = phase_r[FRAC_W +: FRAME_AW];
  assign over    = {1'b0, idx_raw} >= len;
  assign stopped = !loop_r && (fin_r || over);

  // store write straight from an accepted write word
  always_comb begin
    mem_wr.en         = accept && (in_word.req_type == REQ_WRITE);
    mem_wr.addr       = in_word.frame_index;
    mem_wr.data.left  = in_word.sample_left;
    mem_wr.data.right = in_word.sample_right;
  end

  // neighbour fetch order: ym, y0, y1, y2
  always_comb begin
    case (cnt_r)
      3'd0:    rd_addr = im_r;
      3'd1:    rd_addr = idx_r;
      3'd2:    rd_addr = i1_r;
      default: rd_addr = i2_r;
    endcase
  end

  hrsp_store u_store (
    .clk     (clk),
    .wr      (mem_wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // channel samples; mono mode reads channel 0 for both outputs
  always_comb begin
    if (ch_r && stereo_r) begin
      ym = ACC_W'(y_r[0].right);
      y0 = ACC_W'(y_r[1].right);
      y1 = ACC_W'(y_r[2].right);
      y2 = ACC_W'(y_r[3].right);
    end else begin
      ym = ACC_W'(y_r[0].left);
      y0 = ACC_W'(y_r[1].left);
      y1 = ACC_W'(y_r[2].left);
      y2 = ACC_W'(y_r[3].left);
    end
  end

  // doubled Hermite coefficients
  always_comb begin
    coef_a = ACC_W'(3) * (y0 - y1) + (y2 - ym);
    coef_b = ACC_W'(2) * ym - ACC_W'(5) * y0 + ACC_W'(4) * y1 - y2;
    coef_c = y1 - ym;
    coef_d = ACC_W'(2) * y0;
  end

  // MAC schedule: load A, then three Horner steps on the fraction, then gain
  always_comb begin
    mac_op.en     = 1'b0;
    mac_op.rnd    = 1'b0;
    mac_op.mul_b  = '0;
    mac_op.addend = coef_a;
    if (state_r == ST_COEF) begin
      mac_op.en = 1'b1;
    end else if (state_r == ST_MAC) begin
      mac_op.en = 1'b1;
      case (cnt_r)
        3'd0: begin
          mac_op.mul_b  = MUL_B_W'(phase_r[FRAC_W-1:0]);
          mac_op.addend = coef_b_r;
        end
        3'd1: begin
          mac_op.mul_b  = MUL_B_W'(phase_r[FRAC_W-1:0]);
          mac_op.addend = coef_c_r;
        end
        3'd2: begin
          mac_op.mul_b  = MUL_B_W'(phase_r[FRAC_W-1:0]);
          mac_op.addend = coef_d_r;
        end
        default: begin
          mac_op.rnd    = 1'b1;
          mac_op.mul_b  = MUL_B_W'(gain_r);
          mac_op.addend = '0;
        end
      endcase
    end
  end

  hrsp_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .op    (mac_op),
    .res   (mac_res)
  );

  // output saturation
  always_comb begin
    if (mac_res > SAT_MAX) begin
      sat_val = SAT_MAX[SAMPLE_W-1:0];
    end else if (mac_res < SAT_MIN) begin
      sat_val = SAT_MIN[SAMPLE_W-1:0];
    end else begin
      sat_val = mac_res[SAMPLE_W-1:0];
    end
  end

  // phase advance
  assign next_phase = {1'b0, phase_r} + (PHASE_W + 1)'(rate_r);
  assign end_phase  = {len, {FRAC_W{1'b0}}};

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && (in_word.req_type == REQ_PLAY)) begin
          state_nxt = ST_SETUP;
        end
      end
      ST_SETUP: begin
        state_nxt = stopped ? ST_IDLE : ST_READ;
      end
      ST_READ: begin
        if (cnt_r == 3'd4) begin
          state_nxt = ST_COEF;
        end
      end
      ST_COEF: begin
        state_nxt = ST_MAC;
      end
      ST_MAC: begin
        if (cnt_r == 3'd3) begin
          state_nxt = ST_SAT;
        end
      end
      ST_SAT: begin
        state_nxt = ch_r ? ST_IDLE : ST_COEF;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // outputs and datapath updates
  always_comb begin
    phase_nxt     = phase_r;
    fin_nxt       = fin_r;
    cnt_nxt       = cnt_r;
    ch_nxt        = ch_r;
    out_valid_nxt = 1'b0;
    out_word_nxt  = out_word_r;
    idx_nxt       = idx_r;
    im_nxt        = im_r;
    i1_nxt        = i1_r;
    i2_nxt        = i2_r;
    idx_ext       = '0;
    unique case (state_r)
      ST_IDLE: begin
        cnt_nxt = '0;
        ch_nxt  = 1'b0;
        if (accept && (in_word.req_type == REQ_RESTART)) begin
          phase_nxt = {in_word.frame_index, {FRAC_W{1'b0}}};
          fin_nxt   = 1'b0;
        end
      end
      ST_SETUP: begin
        if (stopped) begin
          fin_nxt               = 1'b1;
          out_valid_nxt         = 1'b1;
          out_word_nxt.out_left  = '0;
          out_word_nxt.out_right = '0;
          out_word_nxt.past_end  = 1'b1;
        end else begin
          idx_nxt = idx_raw;
          if (loop_r) begin
            fin_nxt = 1'b0;
            if (over) begin
              idx_nxt   = '0;
              phase_nxt = {{FRAME_AW{1'b0}}, phase_r[FRAC_W-1:0]};
            end
          end
          idx_ext = {1'b0, idx_nxt};
          // left neighbour
          if (idx_nxt == '0) begin
            im_nxt = loop_r ? FRAME_AW'(len - LEN_W'(1)) : '0;
          end else begin
            im_nxt = idx_nxt - FRAME_AW'(1);
          end
          // right neighbour
          if (idx_ext + LEN_W'(1) < len) begin
            i1_nxt = idx_nxt + FRAME_AW'(1);
          end else begin
            i1_nxt = loop_r ? '0 : idx_nxt;
          end
          // second right neighbour
          if (idx_ext + LEN_W'(2) < len) begin
            i2_nxt = idx_nxt + FRAME_AW'(2);
          end else if (loop_r) begin
            i2_nxt = FRAME_AW'(idx_ext + LEN_W'(2) - len);
          end else begin
            i2_nxt = i1_nxt;
          end
        end
      end
      ST_READ: begin
        cnt_nxt = (cnt_r == 3'd4) ? 3'd0 : cnt_r + 3'd1;
      end
      ST_COEF: begin
        cnt_nxt = '0;
      end
      ST_MAC: begin
        cnt_nxt = (cnt_r == 3'd3) ? 3'd0 : cnt_r + 3'd1;
      end
      ST_SAT: begin
        ch_nxt = 1'b1;
        if (ch_r) begin
          out_valid_nxt          = 1'b1;
          out_word_nxt.out_left  = sat_left_r;
          out_word_nxt.out_right = sat_val;
          out_word_nxt.past_end  = 1'b0;
          if (loop_r) begin
            phase_nxt = (next_phase >= end_phase) ? PHASE_W'(next_phase - end_phase)
                                                  : next_phase[PHASE_W-1:0];
          end else if (next_phase >= end_phase) begin
            fin_nxt = 1'b1;
          end else begin
            phase_nxt = next_phase[PHASE_W-1:0];
          end
        end
      end
      default: begin
        cnt_nxt = '0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= '0;
      fin_r       <= 1'b0;
      cnt_r       <= '0;
      ch_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      fin_r       <= fin_nxt;
      cnt_r       <= cnt_nxt;
      ch_r        <= ch_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r   <= GAIN_RST;
      rate_r   <= RATE_RST;
      loop_r   <= 1'b0;
      frames_r <= FRAMES_RST;
      stereo_r <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GAIN:   gain_r   <= cfg_wdata[GAIN_W-1:0];
        CFG_RATE:   rate_r   <= cfg_wdata[RATE_W-1:0];
        CFG_LOOP:   loop_r   <= cfg_wdata[0];
        CFG_FRAMES: frames_r <= cfg_wdata[LEN_W-1:0];
        CFG_STEREO: stereo_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    im_r       <= im_nxt;
    i1_r       <= i1_nxt;
    i2_r       <= i2_nxt;
    out_word_r <= out_word_nxt;
    // neighbour frames shift in as the reads return
    if ((state_r == ST_READ) && (cnt_r != 3'd0)) begin
      y_r[0] <= y_r[1];
      y_r[1] <= y_r[2];
      y_r[2] <= y_r[3];
      y_r[3] <= rd_data;
    end
    if (state_r == ST_COEF) begin
      coef_b_r <= coef_b;
      coef_c_r <= coef_c;
      coef_d_r <= coef_d;
    end
    if ((state_r == ST_SAT) && !ch_r) begin
      sat_left_r <= sat_val;
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // checks
  `HRSP_ASSERT_IMP(a_strobe_idle, out_valid, !busy, "result strobe while sequencer busy")
  `HRSP_ASSERT_NXT(a_strobe_single, out_valid, !out_valid, "result strobe longer than one cycle")
  `HRSP_ASSERT_NXT(a_play_busy, accept && (in_word.req_type == REQ_PLAY), busy,
                   "play word did not start the sequencer")
  `HRSP_ASSERT_IMP(a_past_end_zero, out_valid && out_word.past_end,
                   (out_word.out_left == '0) && (out_word.out_right == '0),
                   "past_end result carries nonzero samples")
  `HRSP_ASSERT_IMP(a_cnt_range, (state_r == ST_MAC), (cnt_r <= 3'd3),
                   "MAC step counter out of range")

endmodule

[rtl/hrsp_store.sv]
// Sample frame memory: one write port, one registered read port.
// Depends on hrsp_pkg.
module hrsp_store import hrsp_pkg::*; (
  input  logic                clk,
  input  hrsp_mem_wr_t        wr,
  input  logic [FRAME_AW-1:0] rd_addr,
  output hrsp_frame_t         rd_data
);

  hrsp_frame_t mem [MAX_FRAMES];
  hrsp_frame_t rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/hrsp_mac.sv]
// Shared multiply-accumulate unit used for every Horner step and the gain step.
// Depends on hrsp_pkg.
module hrsp_mac import hrsp_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  hrsp_mac_op_t            op,
  output logic signed [ACC_W-1:0] res
);

  logic signed [ACC_W-1:0]  res_r;
  logic signed [ACC_W-1:0]  res_nxt;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] sum;

  // res * b, optional half-LSB rounding, floor shift by the fraction width, add
  always_comb begin
    prod    = res_r * op.mul_b;
    sum     = prod + (op.rnd ? PROD_W'({ROUND_HALF}) : '0);
    res_nxt = sum[FRAC_W +: ACC_W] + op.addend;
  end

  // accumulator starts from zero so the load step (b = 0) is always defined
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r <= '0;
    end else if (op.en) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

[tb/tb_top.sv]
// Self-checking testbench for hermite_resampling_sample_player_top: fills the sample store,
// runs directed and random command words, and scores every output frame.
// Depends on hrsp_pkg and the player RTL; needs no other files.
module tb_top;
  import hrsp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] REQ_NONE    = 2'd3;   // undefined request, ignored by the block
  localparam int         STALL_LIMIT = 2000;
  localparam int         DRAIN_WAIT  = 30;
  localparam int         PHASE_ITEMS = 160;
  localparam int         RAND_PHASES = 8;
  localparam int         FILL_FRAMES = 256;

  // Predicts one output frame per play word and scores the block's frames
  class resample_scoreboard;
    logic signed [SAMPLE_W-1:0] left_mem  [MAX_FRAMES];
    logic signed [SAMPLE_W-1:0] right_mem [MAX_FRAMES];
    bit [PHASE_W-1:0] phase;
    bit               finished;
    bit [GAIN_W-1:0]  gain;
    bit [RATE_W-1:0]  rate;
    bit               loop_on;
    bit [LEN_W-1:0]   frames;
    bit               stereo_on;
    hrsp_out_t        expected_frames[$];
    int               errors;

    function new();
      phase     = '0;
      finished  = 1'b0;
      gain      = GAIN_RST;
      rate      = RATE_RST;
      loop_on   = 1'b0;
      frames    = FRAMES_RST;
      stereo_on = 1'b1;
      errors    = 0;
    endfunction

    function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_GAIN:   gain      = data[GAIN_W-1:0];
        CFG_RATE:   rate      = data[RATE_W-1:0];
        CFG_LOOP:   loop_on   = data[0];
        CFG_FRAMES: frames    = data[LEN_W-1:0];
        CFG_STEREO: stereo_on = data[0];
        default: ;
      endcase
    endfunction

    // x-form cubic Hermite on doubled coefficients, then gain, rounding and saturation
    function logic signed [SAMPLE_W-1:0] hermite(longint frac, longint ym, longint y0,
                                                 longint y1, longint y2);
      longint a, b, c, acc, lim;
      lim = longint'(1) << (SAMPLE_W - 1);
      a   = 3 * (y0 - y1) + (y2 - ym);
      b   = 2 * ym - 5 * y0 + 4 * y1 - y2;
      c   = y1 - ym;
      acc = ((a * frac) >>> FRAC_W) + b;
      acc = ((acc * frac) >>> FRAC_W) + c;
      acc = ((acc * frac) >>> FRAC_W) + 2 * y0;
      acc = (acc * longint'(gain) + longint'(ROUND_HALF)) >>> 16;
      if (acc > lim - 1) acc = lim - 1;
      if (acc < -lim)    acc = -lim;
      return SAMPLE_W'(acc);
    endfunction

    // Called for every accepted command word
    function void note_word(hrsp_in_t w);
      int        len, idx, im, i1, i2;
      longint    frac, nxt, span;
      hrsp_out_t res;
      case (w.req_type)
        REQ_WRITE: begin
          left_mem[w.frame_index]  = w.sample_left;
          right_mem[w.frame_index] = w.sample_right;
        end
        REQ_RESTART: begin
          phase    = PHASE_W'(w.frame_index) << FRAC_W;
          finished = 1'b0;
        end
        REQ_PLAY: begin
          len = frames;
          if (len < LEN_MIN) len = LEN_MIN;
          if (len > LEN_MAX) len = LEN_MAX;
          frac = phase[FRAC_W-1:0];
          idx  = phase >> FRAC_W;
          // looping folds an out-of-range position back to frame 0
          if (loop_on) begin
            finished = 1'b0;
            if (idx >= len) begin
              idx   = 0;
              phase = PHASE_W'(frac);
            end
          end else if (finished || idx >= len) begin
            finished      = 1'b1;
            res.out_left  = '0;
            res.out_right = '0;
            res.past_end  = 1'b1;
            expected_frames.push_back(res);
            return;
          end
          // neighbours: wrap when looping, clamp at the edges otherwise
          im = (idx == 0) ? (loop_on ? len - 1 : 0) : idx - 1;
          if (idx + 1 < len) i1 = idx + 1;
          else               i1 = loop_on ? 0 : idx;
          if (idx + 2 < len) i2 = idx + 2;
          else if (loop_on)  i2 = idx + 2 - len;
          else               i2 = i1;
          res.out_left = hermite(frac, left_mem[im], left_mem[idx], left_mem[i1],
                                 left_mem[i2]);
          if (stereo_on)
            res.out_right = hermite(frac, right_mem[im], right_mem[idx], right_mem[i1],
                                    right_mem[i2]);
          else
            res.out_right = res.out_left;
          res.past_end = 1'b0;
          expected_frames.push_back(res);
          // advance the phase
          nxt  = longint'(phase) + longint'(rate);
          span = longint'(len) << FRAC_W;
          if (loop_on) begin
            if (nxt >= span) nxt -= span;
            phase = PHASE_W'(nxt);
          end else if (nxt >= span) begin
            finished = 1'b1;
          end else begin
            phase = PHASE_W'(nxt);
          end
        end
        default: ;
      endcase
    endfunction

    function void report(string what, longint want, longint got);
      errors++;
      $display("%0t ns: %s expected %0d, got %0d", $time, what, want, got);
    endfunction

    // Called for every output frame strobe
    function void check_frame(hrsp_out_t got);
      hrsp_out_t want;
      if (expected_frames.size() == 0) begin
        errors++;
        $display("%0t ns: unexpected frame, expected none, got left %0d right %0d end %0b",
                 $time, got.out_left, got.out_right, got.past_end);
        return;
      end
      want = expected_frames.pop_front();
      if (got.out_left !== want.out_left)   report("out_left", want.out_left, got.out_left);
      if (got.out_right !== want.out_right) report("out_right", want.out_right, got.out_right);
      if (got.past_end !== want.past_end)   report("past_end", want.past_end, got.past_end);
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  hrsp_in_t              in_word;
  logic                  out_valid;
  hrsp_out_t             out_word;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  resample_scoreboard sb = new();
  bit idle_on;
  int quiet_cycles;

  hermite_resampling_sample_player_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Monitor: sample pre-edge values, feed the scoreboard, and watch for a hang
  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_frame(out_word);
    if (rst_n && start && !busy) sb.note_word(in_word);
    if (rst_n && cfg_we) sb.apply_reg(cfg_index, cfg_wdata);
    if (rst_n && (out_valid || (start && !busy) || cfg_we))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(7))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2:       return SAMPLE_W'(int'($urandom_range(127)) - 64);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic hrsp_in_t make_word(logic [1:0] req, int idx,
                                         logic signed [SAMPLE_W-1:0] l,
                                         logic signed [SAMPLE_W-1:0] r);
    hrsp_in_t w;
    w.req_type     = req;
    w.frame_index  = FRAME_AW'(idx);
    w.sample_left  = l;
    w.sample_right = r;
    return w;
  endfunction

  // Present one command word, with optional random idle before it
  task automatic send_word(input hrsp_in_t w);
    int gap;
    gap = 0;
    if (idle_on) begin
      while ($urandom_range(99) < 26) gap++;
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (busy);
  endtask

  task automatic play_word();
    send_word(make_word(REQ_PLAY, $urandom_range(4095), rand_sample(), rand_sample()));
  endtask

  task automatic restart_word(input int pos);
    send_word(make_word(REQ_RESTART, pos, rand_sample(), rand_sample()));
  endtask

  // Wait until every frame is back and any write or restart has finished
  task automatic settle();
    start <= 1'b0;
    while (sb.expected_frames.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // Write all registers while the block is idle
  task automatic set_regs(input int g, input int r, input int lp, input int fr, input int st);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_GAIN;
    cfg_wdata <= CFG_DATA_W'(g);
    @(posedge clk);
    cfg_index <= CFG_RATE;
    cfg_wdata <= CFG_DATA_W'(r);
    @(posedge clk);
    cfg_index <= CFG_LOOP;
    cfg_wdata <= CFG_DATA_W'(lp);
    @(posedge clk);
    cfg_index <= CFG_FRAMES;
    cfg_wdata <= CFG_DATA_W'(fr);
    @(posedge clk);
    cfg_index <= CFG_STEREO;
    cfg_wdata <= CFG_DATA_W'(st);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int       g, r, lp, fr, st, cur_len, count, pick, pos, lo, hi;
    hrsp_in_t w;
    start     <= 1'b0;
    in_word   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    rst_n     <= 1'b0;
    idle_on   = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Fill the low frames; random lengths stay within them, so no play reads
    // an unwritten frame
    for (int i = 0; i < FILL_FRAMES; i++)
      send_word(make_word(REQ_WRITE, i, rand_sample(), rand_sample()));

    // Directed: full-scale alternating frames at both ends of the store
    idle_on = 1'b1;
    send_word(make_word(REQ_WRITE, 0, 16'sh7fff, 16'sh8000));
    send_word(make_word(REQ_WRITE, 1, 16'sh8000, 16'sh7fff));
    send_word(make_word(REQ_WRITE, 2, 16'sh7fff, 16'sh8000));
    send_word(make_word(REQ_WRITE, 3, 16'sh8000, 16'sh7fff));
    send_word(make_word(REQ_WRITE, 4093, 16'sh8000, 16'sh7fff));
    send_word(make_word(REQ_WRITE, 4094, 16'sh7fff, 16'sh8000));
    send_word(make_word(REQ_WRITE, 4095, 16'sh8000, 16'sh7fff));
    // first frame clamps its left neighbour
    restart_word(0);
    play_word();
    play_word();
    // last frame: run off the end, stay silent, ignore an undefined request
    restart_word(4095);
    play_word();
    play_word();
    send_word(make_word(REQ_NONE, 4095, 16'sh7fff, 16'sh8000));
    play_word();
    // looping mono at maximum gain and rate, length below the minimum
    set_regs(65535, 262143, 1, 2, 0);
    restart_word(0);
    play_word();
    play_word();
    play_word();
    restart_word(4000);
    play_word();
    // zero gain, zero rate, length above the store size
    set_regs(0, 0, 0, 8191, 1);
    restart_word(4094);
    play_word();
    // shortest length without loop: reach the end, then restart beyond it
    set_regs(32768, 98304, 0, 4, 1);
    restart_word(2);
    play_word();
    play_word();
    restart_word(9);
    play_word();

    // Random phases, each with its own register setting
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case ($urandom_range(3))
        0:       g = 0;
        1:       g = 65535;
        2:       g = 32768;
        default: g = $urandom_range(65535);
      endcase
      case ($urandom_range(5))
        0:       r = 0;
        1:       r = 262143;
        2:       r = 65536;
        3:       r = $urandom_range(262143);
        default: r = $urandom_range(131072, 8192);
      endcase
      case ($urandom_range(6))
        0:       fr = $urandom_range(3);
        1:       fr = FILL_FRAMES;
        2:       fr = $urandom_range(FILL_FRAMES, 4);
        default: fr = $urandom_range(48, 4);
      endcase
      lp = $urandom_range(1);
      st = $urandom_range(1);
      set_regs(g, r, lp, fr, st);
      cur_len = (fr < LEN_MIN) ? LEN_MIN : ((fr > LEN_MAX) ? LEN_MAX : fr);
      idle_on = (ph != 2);   // one whole phase runs back to back
      restart_word($urandom_range(cur_len - 1));
      count = 0;
      while (count < PHASE_ITEMS) begin
        pick = $urandom_range(99);
        if (pick < 58) begin
          play_word();
          count++;
        end else if (pick < 74) begin
          pos = ($urandom_range(99) < 60) ? $urandom_range(63) : $urandom_range(4095);
          send_word(make_word(REQ_WRITE, pos, rand_sample(), rand_sample()));
          count++;
        end else if (pick < 96) begin
          // restarts cluster around the end of the used length
          case ($urandom_range(4))
            0, 1: begin
              lo  = (cur_len > 3) ? cur_len - 3 : 0;
              hi  = (cur_len + 2 > 4095) ? 4095 : cur_len + 2;
              pos = $urandom_range(hi, lo);
            end
            2, 3:    pos = $urandom_range(cur_len - 1);
            default: pos = $urandom_range(4095);
          endcase
          restart_word(pos);
          count++;
        end else begin
          w = make_word(REQ_NONE, $urandom_range(4095), rand_sample(), rand_sample());
          send_word(w);
        end
      end
    end

    settle();
    if (sb.errors == 0 && sb.expected_frames.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
